FILE: hw/rtl/slpm_pkg.sv
// ----------------------------------------------------------------------------
// slpm_pkg
// Shared types and codes for the LIKE pattern matcher: action codes,
// token kinds, wildcard characters, default store capacity.
// ----------------------------------------------------------------------------
package slpm_pkg;

  localparam int unsigned DefaultCapacity = 32;

  localparam int unsigned ChW = 16;

  // action codes
  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_PATTERN = 3'd1;
  localparam logic [2:0] ACT_SUBJECT = 3'd2;
  localparam logic [2:0] ACT_FINISH  = 3'd3;
  localparam logic [2:0] ACT_NULL    = 3'd4;

  // token kinds
  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_ANY_ONE = 2'd1;
  localparam logic [1:0] KIND_RUN     = 2'd2;
  localparam logic [1:0] KIND_NEVER   = 2'd3;

  localparam logic [ChW-1:0] CH_RUN = 16'h0025;
  localparam logic [ChW-1:0] CH_ONE = 16'h005F;
  localparam logic [ChW-1:0] CH_ESC = 16'h005C;

  typedef struct packed {
    logic [1:0]     kind;
    logic [ChW-1:0] ch;
  } token_t;

  // compiler state seen by the position tracker and the result stage
  typedef struct packed {
    logic esc_pending;  // trailing backslash not yet committed
    logic ovf;          // overflow flag as stored
    logic ovf_commit;   // overflow flag after a pending escape is committed
  } cmp_status_t;

endpackage

FILE: hw/rtl/slpm_compiler.sv
// ----------------------------------------------------------------------------
// slpm_compiler
// Turns pattern characters into tokens and holds the token store, the
// pattern length, the escape / run-collapse flags and the overflow flag.
// ----------------------------------------------------------------------------
module slpm_compiler #(
  parameter int unsigned Capacity = slpm_pkg::DefaultCapacity,
  localparam int unsigned LenW = $clog2(Capacity + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [2:0]                action,
  input  logic [slpm_pkg::ChW-1:0]  ch,
  output slpm_pkg::token_t          tokens [Capacity],
  output logic [LenW-1:0]           len,
  output slpm_pkg::cmp_status_t     status
);

  logic esc_pending;
  logic prev_run;
  logic ovf;

  logic                 esc_pending_next;
  logic                 prev_run_next;
  logic                 append;
  slpm_pkg::token_t     append_tok;
  logic                 full;

  assign full = (len == LenW'(Capacity));

  assign status.esc_pending = esc_pending;
  assign status.ovf         = ovf;
  assign status.ovf_commit  = ovf | (esc_pending & full);

  always_comb begin
    esc_pending_next = esc_pending;
    prev_run_next    = prev_run;
    append           = 1'b0;
    append_tok.kind  = slpm_pkg::KIND_LITERAL;
    append_tok.ch    = ch;
    unique case (action) inside
      slpm_pkg::ACT_PATTERN: begin
        if (esc_pending) begin
          esc_pending_next = 1'b0;
          prev_run_next    = 1'b0;
          append           = 1'b1;
        end else if (ch == slpm_pkg::CH_ESC) begin
          esc_pending_next = 1'b1;
        end else if (ch == slpm_pkg::CH_RUN) begin
          // consecutive runs collapse into one token
          append          = !prev_run;
          append_tok.kind = slpm_pkg::KIND_RUN;
          append_tok.ch   = '0;
          prev_run_next   = 1'b1;
        end else if (ch == slpm_pkg::CH_ONE) begin
          append          = 1'b1;
          append_tok.kind = slpm_pkg::KIND_ANY_ONE;
          append_tok.ch   = '0;
          prev_run_next   = 1'b0;
        end else begin
          append        = 1'b1;
          prev_run_next = 1'b0;
        end
      end
      slpm_pkg::ACT_SUBJECT, slpm_pkg::ACT_FINISH, slpm_pkg::ACT_NULL: begin
        // trailing lone backslash becomes a never-matching token
        if (esc_pending) begin
          esc_pending_next = 1'b0;
          prev_run_next    = 1'b0;
          append           = 1'b1;
          append_tok.kind  = slpm_pkg::KIND_NEVER;
          append_tok.ch    = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len         <= '0;
      esc_pending <= 1'b0;
      prev_run    <= 1'b0;
      ovf         <= 1'b0;
    end else if (en) begin
      if (action == slpm_pkg::ACT_CLEAR) begin
        len         <= '0;
        esc_pending <= 1'b0;
        prev_run    <= 1'b0;
        ovf         <= 1'b0;
      end else begin
        esc_pending <= esc_pending_next;
        prev_run    <= prev_run_next;
        if (append && !ovf) begin
          if (full) begin
            ovf <= 1'b1;
          end else begin
            len <= len + LenW'(1);
          end
        end
      end
    end
  end

  // token store: written at the current length, every entry read in place
  for (genvar i = 0; i < Capacity; i++) begin : g_store
    always_ff @(posedge clk) begin
      if (en && append && !ovf && (action != slpm_pkg::ACT_CLEAR) &&
          (len == LenW'(i))) begin
        tokens[i] <= append_tok;
      end
    end
  end

endmodule

FILE: hw/rtl/slpm_tracker.sv
// ----------------------------------------------------------------------------
// slpm_tracker
// Bit-parallel vector of active pattern positions. Advances one subject
// character per enabled cycle and forms the verdict on finish.
// ----------------------------------------------------------------------------
module slpm_tracker #(
  parameter int unsigned Capacity = slpm_pkg::DefaultCapacity,
  localparam int unsigned LenW = $clog2(Capacity + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [2:0]                action,
  input  logic [slpm_pkg::ChW-1:0]  ch,
  input  slpm_pkg::token_t          tokens [Capacity],
  input  logic [LenW-1:0]           len,
  input  slpm_pkg::cmp_status_t     status,
  output logic                      hit
);

  logic [Capacity:0]   active;
  logic [Capacity:0]   closed;
  logic [Capacity:0]   active_next;
  logic [Capacity-1:0] is_run;
  logic [Capacity-1:0] steps;

  for (genvar i = 0; i < Capacity; i++) begin : g_pos
    logic in_use;
    assign in_use   = (len > LenW'(i));
    assign is_run[i] = in_use && (tokens[i].kind == slpm_pkg::KIND_RUN);
    assign steps[i]  = in_use &&
                       ((tokens[i].kind == slpm_pkg::KIND_ANY_ONE) ||
                        ((tokens[i].kind == slpm_pkg::KIND_LITERAL) &&
                         (tokens[i].ch == ch)));
  end

  // run tokens never sit next to each other, so one closure step suffices
  assign closed = active | {active[Capacity-1:0] & is_run, 1'b0};

  assign active_next = {closed[Capacity-1:0] & steps, 1'b0} |
                       {1'b0, closed[Capacity-1:0] & is_run};

  // a pending escape appends a never token, which cannot reach the end
  assign hit = closed[len] && !status.esc_pending && !status.ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= (Capacity + 1)'(1);
    end else if (en) begin
      unique case (action) inside
        slpm_pkg::ACT_SUBJECT: begin
          active <= active_next;
        end
        slpm_pkg::ACT_CLEAR, slpm_pkg::ACT_FINISH, slpm_pkg::ACT_NULL: begin
          active <= (Capacity + 1)'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/sql_like_pattern_matcher.sv
// ----------------------------------------------------------------------------
// sql_like_pattern_matcher
// SQL LIKE matcher with backslash escape: pattern compiled into tokens,
// subject tracked as a vector of active pattern positions.
//
//   channel  handshake                  payload
//   item     item_valid / item_stall    action[2:0], ch[15:0]
//   result   result_valid / result_stall matched, overflow
//
// One request per cycle while item_stall is low; each passes an input
// register, then the token store and position vector update together
// with the result register.
// rst (synchronous) empties the pattern and leaves only position 0 active.
// A stalled result holds the input register only for finish or null
// requests; other requests keep flowing.
// ----------------------------------------------------------------------------
module sql_like_pattern_matcher #(
  parameter int unsigned PatternCapacity = slpm_pkg::DefaultCapacity
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [2:0]                action,
  input  logic [slpm_pkg::ChW-1:0]  ch,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      matched,
  output logic                      overflow
);

  localparam int unsigned LenW = $clog2(PatternCapacity + 1);

  logic                      s1_valid;
  logic [2:0]                s1_action;
  logic [slpm_pkg::ChW-1:0]  s1_ch;
  logic                      s1_result;
  logic                      s1_go;

  slpm_pkg::token_t          tokens [PatternCapacity];
  logic [LenW-1:0]           len;
  slpm_pkg::cmp_status_t     status;
  logic                      hit;

  assign s1_result  = (s1_action == slpm_pkg::ACT_FINISH) ||
                      (s1_action == slpm_pkg::ACT_NULL);
  assign s1_go      = s1_valid && (!s1_result || !result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      s1_action <= action;
      s1_ch     <= ch;
    end
  end

  slpm_compiler #(
    .Capacity (PatternCapacity)
  ) u_compiler (
    .clk    (clk),
    .rst    (rst),
    .en     (s1_go),
    .action (s1_action),
    .ch     (s1_ch),
    .tokens (tokens),
    .len    (len),
    .status (status)
  );

  slpm_tracker #(
    .Capacity (PatternCapacity)
  ) u_tracker (
    .clk    (clk),
    .rst    (rst),
    .en     (s1_go),
    .action (s1_action),
    .ch     (s1_ch),
    .tokens (tokens),
    .len    (len),
    .status (status),
    .hit    (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && s1_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_result) begin
      matched  <= (s1_action == slpm_pkg::ACT_FINISH) && hit;
      overflow <= status.ovf_commit;
    end
  end

endmodule

FILE: sim/like_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// like_verdict_checker
// Watches both channels of the LIKE matcher. It keeps its own token store
// and position vector, updates them on every accepted request, and queues
// the verdict that each finish or null request must produce. Each accepted
// result is compared field by field against the oldest queued verdict.
// ----------------------------------------------------------------------------
module like_verdict_checker #(
  parameter int unsigned Capacity = slpm_pkg::DefaultCapacity
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic                     item_stall,
  input  logic [2:0]               action,
  input  logic [slpm_pkg::ChW-1:0] ch,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic                     matched,
  input  logic                     overflow,
  output int                       fail_count,
  output int                       outstanding
);

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  slpm_pkg::token_t  tokens [Capacity];
  int unsigned       tok_len;
  logic              esc_pending;
  logic              after_run;
  logic              ovf_flag;
  logic [Capacity:0] live;
  verdict_t          verdict_q [$];

  function automatic void restart_subject();
    live    = '0;
    live[0] = 1'b1;
  endfunction

  function automatic void add_token(input logic [1:0] kind,
                                    input logic [slpm_pkg::ChW-1:0] c);
    if (ovf_flag) return;
    if (tok_len >= Capacity) begin
      ovf_flag = 1'b1;
      return;
    end
    tokens[tok_len] = {kind, c};
    tok_len++;
  endfunction

  // a lone backslash at the end of the pattern becomes a token that never matches
  function automatic void flush_escape();
    if (esc_pending) begin
      esc_pending = 1'b0;
      after_run   = 1'b0;
      add_token(slpm_pkg::KIND_NEVER, '0);
    end
  endfunction

  // an active run position also activates the one after it (run of length zero);
  // ascending order lets this carry through chains
  function automatic void spread_runs();
    for (int i = 0; i < tok_len; i++)
      if (live[i] && tokens[i].kind == slpm_pkg::KIND_RUN) live[i+1] = 1'b1;
  endfunction

  // updates the model; returns 1 when the request yields a verdict
  function automatic bit predict(input logic [2:0] act,
                                 input logic [slpm_pkg::ChW-1:0] c,
                                 output verdict_t v);
    logic [Capacity:0] nxt;
    v = '0;
    unique case (act)
      slpm_pkg::ACT_CLEAR: begin
        tok_len     = 0;
        esc_pending = 1'b0;
        after_run   = 1'b0;
        ovf_flag    = 1'b0;
        restart_subject();
        return 1'b0;
      end
      slpm_pkg::ACT_PATTERN: begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          after_run   = 1'b0;
          add_token(slpm_pkg::KIND_LITERAL, c);
        end else if (c == slpm_pkg::CH_ESC) begin
          esc_pending = 1'b1;
        end else if (c == slpm_pkg::CH_RUN) begin
          if (!after_run) add_token(slpm_pkg::KIND_RUN, '0);
          after_run = 1'b1;
        end else if (c == slpm_pkg::CH_ONE) begin
          after_run = 1'b0;
          add_token(slpm_pkg::KIND_ANY_ONE, '0);
        end else begin
          after_run = 1'b0;
          add_token(slpm_pkg::KIND_LITERAL, c);
        end
        return 1'b0;
      end
      slpm_pkg::ACT_SUBJECT: begin
        flush_escape();
        spread_runs();
        nxt = '0;
        for (int i = 0; i < tok_len; i++) begin
          if (live[i]) begin
            case (tokens[i].kind)
              slpm_pkg::KIND_RUN:     nxt[i] = 1'b1;
              slpm_pkg::KIND_ANY_ONE: nxt[i+1] = 1'b1;
              slpm_pkg::KIND_LITERAL: if (tokens[i].ch == c) nxt[i+1] = 1'b1;
              default: ;
            endcase
          end
        end
        live = nxt;
        return 1'b0;
      end
      slpm_pkg::ACT_FINISH: begin
        flush_escape();
        spread_runs();
        v.matched  = live[tok_len] && !ovf_flag;
        v.overflow = ovf_flag;
        restart_subject();
        return 1'b1;
      end
      slpm_pkg::ACT_NULL: begin
        flush_escape();
        v.overflow = ovf_flag;
        restart_subject();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      tok_len     = 0;
      esc_pending = 1'b0;
      after_run   = 1'b0;
      ovf_flag    = 1'b0;
      restart_subject();
      verdict_q.delete();
    end else begin
      // results leave only after their request has passed the input and result registers, so check first
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected: matched=%0b overflow=%0b",
                   $time, matched, overflow);
        end else begin
          want = verdict_q.pop_front();
          if (matched !== want.matched) begin
            fail_count++;
            $display("%0t: matched expected %0b actual %0b", $time, want.matched, matched);
          end
          if (overflow !== want.overflow) begin
            fail_count++;
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                     overflow);
          end
        end
      end
      if (item_valid && !item_stall)
        if (predict(action, ch, want)) verdict_q.push_back(want);
    end
    outstanding = verdict_q.size();
  end

endmodule

FILE: sim/tb_sql_like_pattern_matcher.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sql_like_pattern_matcher
// Drives the LIKE matcher with a directed opening (wildcards, escapes,
// run collapse, never token, ignored codes) and then random pattern and
// subject sequences, most of them subjects built to fit the pattern.
// Both channels idle in random bursts; a checker predicts every verdict.
// ----------------------------------------------------------------------------
module tb_sql_like_pattern_matcher;

  localparam int TotalItems = 900;
  localparam int CalmItems  = 100;
  localparam int IdleLimit  = 1000;

  localparam int unsigned ChW = slpm_pkg::ChW;

  // action codes the block ignores
  localparam logic [2:0] ActUnusedLo = 3'd5;
  localparam logic [2:0] ActUnusedHi = 3'd7;

  localparam logic [ChW-1:0] ChA = 16'h0061;
  localparam logic [ChW-1:0] ChB = 16'h0062;

  logic           clk;
  logic           rst          = 1'b1;
  logic           item_valid   = 1'b0;
  logic [2:0]     action       = slpm_pkg::ACT_CLEAR;
  logic [ChW-1:0] ch           = '0;
  logic           result_stall = 1'b0;
  logic           item_stall;
  logic           result_valid;
  logic           matched;
  logic           overflow;

  int  fail_count;
  int  outstanding;
  int  sent       = 0;
  int  idle_count = 0;
  int  stall_left = 0;
  bit  calm       = 1'b0;

  sql_like_pattern_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .ch           (ch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .matched      (matched),
    .overflow     (overflow)
  );

  like_verdict_checker #(
    .Capacity (slpm_pkg::DefaultCapacity)
  ) verdict_chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .ch           (ch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .matched      (matched),
    .overflow     (overflow),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stretches, each stalled or free at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (calm) begin
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      result_stall <= ($urandom_range(0, 2) == 0);
      stall_left   <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  function automatic logic [ChW-1:0] pick_pattern_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return ChA;
      3, 4:    return ChB;
      5, 6:    return slpm_pkg::CH_RUN;
      7:       return slpm_pkg::CH_ONE;
      8:       return slpm_pkg::CH_ESC;
      default: return ChW'($urandom);
    endcase
  endfunction

  function automatic logic [ChW-1:0] pick_subject_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ChA;
      4, 5, 6:    return ChB;
      7:          return '0;
      default:    return ChW'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [2:0] act, input logic [ChW-1:0] c);
    if (!calm && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    ch         <= c;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (act <= slpm_pkg::ACT_NULL) sent++;
    if (sent == TotalItems - CalmItems) calm <= 1'b1;
  endtask

  // hold the sender until every verdict in flight has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [ChW-1:0] pat [$];
    logic [ChW-1:0] subj [$];
    bit             have_pat;
    bit             esc;
    bit             paused;
    int             plen;

    have_pat = 1'b0;
    paused   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty pattern: only the empty subject fits; zero char is ordinary
    send_request(slpm_pkg::ACT_FINISH, 16'hFFFF);
    send_request(slpm_pkg::ACT_SUBJECT, 16'h0000);
    send_request(slpm_pkg::ACT_FINISH, 16'h0000);
    send_request(slpm_pkg::ACT_NULL, 16'hFFFF);
    // extreme literals, collapsed runs, one-char wildcard
    send_request(slpm_pkg::ACT_PATTERN, 16'hFFFF);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_RUN);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_RUN);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_ONE);
    send_request(slpm_pkg::ACT_PATTERN, 16'h0000);
    send_request(slpm_pkg::ACT_SUBJECT, 16'hFFFF);
    send_request(slpm_pkg::ACT_SUBJECT, 16'hAAAA);
    // pattern grows while a subject is in progress
    send_request(slpm_pkg::ACT_PATTERN, 16'h5555);
    send_request(slpm_pkg::ACT_SUBJECT, 16'h0000);
    send_request(slpm_pkg::ACT_SUBJECT, 16'h5555);
    send_request(slpm_pkg::ACT_FINISH, 16'h5555);
    send_request(ActUnusedLo, 16'hFFFF);
    send_request(ActUnusedHi, 16'h0000);
    // escaped wildcards and backslash, then a trailing backslash
    send_request(slpm_pkg::ACT_CLEAR, 16'hFFFF);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_ESC);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_RUN);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_ESC);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_ONE);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_ESC);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_ESC);
    send_request(slpm_pkg::ACT_PATTERN, slpm_pkg::CH_ESC);
    send_request(slpm_pkg::ACT_SUBJECT, slpm_pkg::CH_RUN);
    send_request(slpm_pkg::ACT_SUBJECT, slpm_pkg::CH_ONE);
    send_request(slpm_pkg::ACT_SUBJECT, slpm_pkg::CH_ESC);
    send_request(slpm_pkg::ACT_FINISH, 16'h0000);
    drain_results();

    while (sent < TotalItems) begin
      if (!have_pat || $urandom_range(0, 2) == 0) begin
        send_request(slpm_pkg::ACT_CLEAR, ChW'($urandom));
        pat.delete();
        have_pat = 1'b1;
        // a few long patterns push the store past capacity
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(36, 52) : $urandom_range(0, 6);
        repeat (plen) pat.push_back(pick_pattern_char());
        foreach (pat[k]) send_request(slpm_pkg::ACT_PATTERN, pat[k]);
      end

      subj.delete();
      if ($urandom_range(0, 2) != 0) begin
        // expand the pattern into a subject that fits, then maybe spoil it
        esc = 1'b0;
        foreach (pat[k]) begin
          if (esc) begin
            subj.push_back(pat[k]);
            esc = 1'b0;
          end else if (pat[k] == slpm_pkg::CH_ESC) begin
            esc = 1'b1;
          end else if (pat[k] == slpm_pkg::CH_RUN) begin
            repeat ($urandom_range(0, 2)) subj.push_back(pick_subject_char());
          end else if (pat[k] == slpm_pkg::CH_ONE) begin
            subj.push_back(ChW'($urandom));
          end else begin
            subj.push_back(pat[k]);
          end
        end
        if (subj.size() != 0 && $urandom_range(0, 3) == 0)
          subj[$urandom_range(0, subj.size() - 1)] = pick_subject_char();
      end else begin
        repeat ($urandom_range(0, 6)) subj.push_back(pick_subject_char());
      end

      foreach (subj[i]) begin
        if ($urandom_range(0, 29) == 0)
          send_request(3'($urandom_range(ActUnusedLo, ActUnusedHi)), ChW'($urandom));
        if ($urandom_range(0, 39) == 0)
          send_request(slpm_pkg::ACT_PATTERN, pick_pattern_char());
        send_request(slpm_pkg::ACT_SUBJECT, subj[i]);
      end
      if ($urandom_range(0, 9) == 0) send_request(slpm_pkg::ACT_NULL, ChW'($urandom));
      else send_request(slpm_pkg::ACT_FINISH, ChW'($urandom));

      if (!paused && sent >= TotalItems / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
